// ===== sv/rtew_pkg.sv =====
package rtew_pkg;

	// Opcode layout of the word-sized register rotate.
	localparam int DestRegLo = 0;
	localparam int DestRegW = 3;
	localparam int CountSrcBit = 5;
	localparam int LeftBit = 8;
	localparam int CountLo = 9;
	localparam int CountW = 3;

	// The rotated quantity is {X, value}.
	localparam int WordW = 16;
	localparam int RotW = WordW + 1;
	localparam int AmtW = $clog2(RotW);
	localparam int RegCountW = 6;
	localparam int CyclesW = 8;

	localparam logic [RegCountW-1:0] ImmZeroCount = RegCountW'(8);
	localparam logic [CyclesW-1:0] CycleBase = CyclesW'(6);
	localparam logic [RegCountW-1:0] Mod1 = RegCountW'(RotW);
	localparam logic [RegCountW-1:0] Mod2 = RegCountW'(2 * RotW);
	localparam logic [RegCountW-1:0] Mod3 = RegCountW'(3 * RotW);
	localparam logic [AmtW-1:0] RotWAmt = AmtW'(RotW);

	typedef struct packed {
		logic [15:0] opcode;
		logic [15:0] dest_value;
		logic [5:0]  count_reg_value;
		logic        x_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result;
		logic [2:0]  dest_reg;
		logic        x_out;
		logic        n_flag;
		logic        z_flag;
		logic        v_flag;
		logic        c_flag;
		logic [7:0]  cycles;
	} out_item_t;

	typedef struct packed {
		logic [RotW-1:0]     word;
		logic [AmtW-1:0]     amt;
		logic [DestRegW-1:0] dest_reg;
		logic [CyclesW-1:0]  cycles;
	} rot_req_t;

	typedef struct packed {
		logic [RotW-1:0]     word;
		logic [DestRegW-1:0] dest_reg;
		logic [CyclesW-1:0]  cycles;
	} rot_res_t;

endpackage

// ===== sv/rtew_ifs.sv =====
interface rtew_in_if;
	import rtew_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rtew_out_if;
	import rtew_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/rtew_decode.sv =====
module rtew_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rtew_pkg::in_item_t in_data,
	output logic               valid_s1,
	input  logic               ready_s1,
	output rtew_pkg::rot_req_t data_s1
);
	import rtew_pkg::*;

	logic [CountW-1:0]    imm;
	logic [RegCountW-1:0] count;
	logic [RegCountW-1:0] diff;
	logic [AmtW-1:0]      rem;
	logic                 left;
	rot_req_t             nxt;

	always_comb begin
		imm = in_data.opcode[CountLo +: CountW];
		left = in_data.opcode[LeftBit];
		if (in_data.opcode[CountSrcBit]) begin
			count = in_data.count_reg_value;
		end else if (imm == '0) begin
			count = ImmZeroCount;
		end else begin
			count = RegCountW'(imm);
		end

		// The count is below 64, so three compares reduce it modulo 17.
		if (count >= Mod3) begin
			diff = count - Mod3;
		end else if (count >= Mod2) begin
			diff = count - Mod2;
		end else if (count >= Mod1) begin
			diff = count - Mod1;
		end else begin
			diff = count;
		end
		rem = diff[AmtW-1:0];

		// A right rotate is a left rotate by the complement; zero stays zero.
		if (rem == '0) begin
			nxt.amt = '0;
		end else if (left) begin
			nxt.amt = rem;
		end else begin
			nxt.amt = RotWAmt - rem;
		end
		nxt.word = {in_data.x_in, in_data.dest_value};
		nxt.dest_reg = in_data.opcode[DestRegLo +: DestRegW];
		nxt.cycles = CycleBase + {1'b0, count, 1'b0};
	end

	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== sv/rtew_rotate.sv =====
module rtew_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rtew_pkg::rot_req_t in_data,
	output logic               valid_s2,
	input  logic               ready_s2,
	output rtew_pkg::rot_res_t data_s2
);
	import rtew_pkg::*;

	logic [2*RotW-1:0] doubled;
	rot_res_t          nxt;

	always_comb begin
		// The upper half of the doubled word shifted left is the rotation.
		doubled = {in_data.word, in_data.word} << in_data.amt;
		nxt.word = doubled[2*RotW-1:RotW];
		nxt.dest_reg = in_data.dest_reg;
		nxt.cycles = in_data.cycles;
	end

	assign in_ready = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

// ===== sv/rotate_through_extend_word.sv =====
// Throughput: one beat per cycle while the output is not stalled; decode and
// modulo-17 reduction, the rotator, and the flag stage are each one register
// stage with their own valid bit. A stalled output holds only the stages
// behind it that are full. Reset clears the valid bits of all three stages;
// the data registers are not reset.
module rotate_through_extend_word (
	input  logic     clk,
	input  logic     arst_n,
	rtew_in_if.sink  din,
	rtew_out_if.source dout
);
	import rtew_pkg::*;

	logic      valid_s1;
	logic      ready_s1;
	rot_req_t  data_s1;
	logic      valid_s2;
	logic      ready_s2;
	rot_res_t  data_s2;
	logic      valid_s3;
	out_item_t data_s3;
	out_item_t nxt;

	rtew_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.in_data  (din.data),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.data_s1  (data_s1)
	);

	rtew_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (ready_s1),
		.in_data  (data_s1),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.data_s2  (data_s2)
	);

	always_comb begin
		nxt.result = data_s2.word[WordW-1:0];
		nxt.dest_reg = data_s2.dest_reg;
		// With a zero rotation the top bit is still the old X, so C follows it.
		nxt.x_out = data_s2.word[WordW];
		nxt.c_flag = data_s2.word[WordW];
		nxt.n_flag = data_s2.word[WordW-1];
		nxt.z_flag = (data_s2.word[WordW-1:0] == '0);
		nxt.v_flag = 1'b0;
		nxt.cycles = data_s2.cycles;
	end

	assign ready_s2 = !valid_s3 || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			data_s3 <= nxt;
		end
	end

	assign dout.valid = valid_s3;
	assign dout.data = data_s3;

`ifndef NO_ASSERTIONS
	a_free_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!dout.valid |-> din.ready)
		else $error("input not ready while the output stage is empty");

	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> valid_s1)
		else $error("accepted beat did not reach the first stage");

	a_flags_match_result: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.data.z_flag == (dout.data.result == '0)) &&
			(dout.data.n_flag == dout.data.result[WordW-1]) &&
			(dout.data.c_flag == dout.data.x_out) && !dout.data.v_flag)
		else $error("result flags disagree with the result word");

	a_cycles_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.data.cycles >= CycleBase) && !dout.data.cycles[0])
		else $error("cycle cost out of range");
`endif

endmodule
